[hw/rtl/bra_pkg.sv]
// ----------------------------------------------------------------------------
// bra_pkg
// shared types and constants of the banker's resource allocator
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int CUSTOMERS_DEF = 8;
    localparam int RESOURCES_DEF = 4;
    localparam int UNIT_BITS_DEF = 8;
    localparam int AMOUNT_FIELDS = 4;
    localparam int AMOUNT_BITS   = 8;
    localparam int CUST_BITS     = 3;
    localparam int STATUS_BITS   = 3;

    typedef enum logic [1:0] {
        OP_REQUEST   = 2'd0,
        OP_RELEASE   = 2'd1,
        OP_LOAD_MAX  = 2'd2,
        OP_LOAD_AVAIL = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 3'd0,
        ST_OVER_NEED  = 3'd1,
        ST_OVER_AVAIL = 3'd2,
        ST_UNSAFE     = 3'd3,
        ST_OVER_REL   = 3'd4
    } t_status;

endpackage

[hw/rtl/bankers_resource_allocator.sv]
// ----------------------------------------------------------------------------
// bankers_resource_allocator
// banker's algorithm allocator: request, release and load operations with a
// safety check over per-customer allocation and need rows held in memory
// ----------------------------------------------------------------------------
// release and loads pass through the read, execute and output states to result valid
// request: within need and available units it also runs the safety scan, one row read
// per cycle, in passes over all rows until a pass makes no progress, then a check state and, if unsafe, a rollback
// one word is in flight at a time; the input waits until the result is taken
// reset: synchronous active low; a clearing pass over all CUSTOMERS rows writes
// zero rows into the memory before the first word is accepted
module bankers_resource_allocator #(
    parameter int CUSTOMERS = bra_pkg::CUSTOMERS_DEF,
    parameter int RESOURCES = bra_pkg::RESOURCES_DEF,
    parameter int UNIT_BITS = bra_pkg::UNIT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_operation,
    input  logic [bra_pkg::CUST_BITS-1:0]    i_customer,
    input  logic [bra_pkg::AMOUNT_BITS-1:0]  i_amount_0,
    input  logic [bra_pkg::AMOUNT_BITS-1:0]  i_amount_1,
    input  logic [bra_pkg::AMOUNT_BITS-1:0]  i_amount_2,
    input  logic [bra_pkg::AMOUNT_BITS-1:0]  i_amount_3,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [bra_pkg::STATUS_BITS-1:0]  o_status
);
    import bra_pkg::*;

    localparam int CB = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int CW = CB + 1;
    localparam int RW = RESOURCES * UNIT_BITS;
    localparam logic [UNIT_BITS-1:0] UMAX = {UNIT_BITS{1'b1}};

    typedef logic [UNIT_BITS-1:0] t_unit;
    typedef t_unit [RESOURCES-1:0] t_vec;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_ROLL  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    // row memories: allocation and need, one row per customer
    logic [RW-1:0] mem_alloc [CUSTOMERS];
    logic [RW-1:0] mem_need  [CUSTOMERS];
    logic [RW-1:0] r_rd_alloc, r_rd_need;
    logic          wr_en;
    logic [CB-1:0] wr_addr, rd_addr;
    logic [RW-1:0] wr_alloc, wr_need;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_alloc[wr_addr] <= wr_alloc;
            mem_need[wr_addr]  <= wr_need;
        end
        // a row written in the same cycle is forwarded to the read port
        if (wr_en && (wr_addr == rd_addr)) begin
            r_rd_alloc <= wr_alloc;
            r_rd_need  <= wr_need;
        end else begin
            r_rd_alloc <= mem_alloc[rd_addr];
            r_rd_need  <= mem_need[rd_addr];
        end
    end

    t_state              r_state, n_state;
    t_vec                r_avail, n_avail;
    t_vec                r_work, n_work;
    t_vec                r_amt;
    logic [1:0]          r_op;
    logic [CB-1:0]       r_cust;
    logic                r_cust_ok;
    logic [CUSTOMERS-1:0] r_fin, n_fin;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_prog, n_prog;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic                r_ovalid, n_ovalid;
    t_vec                amt_in;
    t_vec                row_a, row_n, wa, wn;
    logic [AMOUNT_BITS-1:0] amt_raw [AMOUNT_FIELDS];

    assign amt_raw[0] = i_amount_0;
    assign amt_raw[1] = i_amount_1;
    assign amt_raw[2] = i_amount_2;
    assign amt_raw[3] = i_amount_3;

    always_comb begin
        for (int r = 0; r < RESOURCES; r++) begin
            if (r < AMOUNT_FIELDS) begin
                amt_in[r] = t_unit'(amt_raw[r % AMOUNT_FIELDS] & AMOUNT_BITS'(UMAX));
            end else begin
                amt_in[r] = '0;
            end
        end
        row_a = t_vec'(r_rd_alloc);
        row_n = t_vec'(r_rd_need);
    end

    function automatic t_unit sat_add(t_unit a, t_unit b);
        logic [UNIT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[UNIT_BITS] ? UMAX : s[UNIT_BITS-1:0];
    endfunction

    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_status = r_status;

    logic over_need, over_avail, over_rel, fits;

    always_comb begin
        over_need = 1'b0; over_avail = 1'b0; over_rel = 1'b0; fits = 1'b1;
        for (int r = 0; r < RESOURCES; r++) begin
            if (r_amt[r] > row_n[r])   over_need = 1'b1;
            if (r_amt[r] > r_avail[r]) over_avail = 1'b1;
            if (r_amt[r] > row_a[r])   over_rel = 1'b1;
            if (row_n[r] > r_work[r])  fits = 1'b0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_avail  = r_avail;
        n_work   = r_work;
        n_fin    = r_fin;
        n_idx    = r_idx;
        n_prog   = r_prog;
        n_status = r_status;
        n_ovalid = r_ovalid;
        wr_en    = 1'b0;
        wr_addr  = r_cust;
        wr_alloc = '0;
        wr_need  = '0;
        rd_addr  = r_cust;
        wa       = row_a;
        wn       = row_n;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[CB-1:0];
                n_idx   = r_idx + CW'(1);
                if (r_idx == CW'(CUSTOMERS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_state  = S_OUT;
                if (r_cust_ok) begin
                    unique case (t_op'(r_op))
                        OP_REQUEST: begin
                            if (over_need) begin
                                n_status = ST_OVER_NEED;
                            end else if (over_avail) begin
                                n_status = ST_OVER_AVAIL;
                            end else begin
                                for (int r = 0; r < RESOURCES; r++) begin
                                    n_avail[r] = r_avail[r] - r_amt[r];
                                    wa[r] = sat_add(row_a[r], r_amt[r]);
                                    wn[r] = row_n[r] - r_amt[r];
                                end
                                wr_en    = 1'b1;
                                wr_alloc = RW'(wa);
                                wr_need  = RW'(wn);
                                n_work   = n_avail;
                                n_fin    = '0;
                                n_idx    = '0;
                                n_prog   = 1'b0;
                                rd_addr  = '0;
                                n_state  = S_SCAN;
                            end
                        end
                        OP_RELEASE: begin
                            if (over_rel) begin
                                n_status = ST_OVER_REL;
                            end else begin
                                for (int r = 0; r < RESOURCES; r++) begin
                                    wa[r] = row_a[r] - r_amt[r];
                                    n_avail[r] = sat_add(r_avail[r], r_amt[r]);
                                    wn[r] = sat_add(row_n[r], r_amt[r]);
                                end
                                wr_en    = 1'b1;
                                wr_alloc = RW'(wa);
                                wr_need  = RW'(wn);
                            end
                        end
                        OP_LOAD_MAX: begin
                            for (int r = 0; r < RESOURCES; r++) begin
                                wn[r] = (r_amt[r] > row_a[r]) ? r_amt[r] - row_a[r] : '0;
                            end
                            wr_en    = 1'b1;
                            wr_alloc = r_rd_alloc;
                            wr_need  = RW'(wn);
                        end
                        OP_LOAD_AVAIL: begin
                            n_avail = r_amt;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // row r_idx is on the read port; the next row is fetched now
                rd_addr = r_idx[CB-1:0] + CB'(1);
                if (r_idx == CW'(CUSTOMERS - 1)) rd_addr = '0;
                if (!r_fin[r_idx[CB-1:0]] && fits) begin
                    for (int r = 0; r < RESOURCES; r++)
                        n_work[r] = sat_add(r_work[r], row_a[r]);
                    n_fin[r_idx[CB-1:0]] = 1'b1;
                    n_prog = 1'b1;
                end
                n_idx = r_idx + CW'(1);
                if (r_idx == CW'(CUSTOMERS - 1)) begin
                    n_idx  = '0;
                    n_prog = 1'b0;
                    if (!(r_prog || (!r_fin[r_idx[CB-1:0]] && fits)))
                        n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                rd_addr = r_cust;
                if (&r_fin) begin
                    n_status = ST_OK;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_ROLL;
                end
            end
            S_ROLL: begin
                // reread of own row finished; undo the tentative grant
                for (int r = 0; r < RESOURCES; r++) begin
                    n_avail[r] = r_avail[r] + r_amt[r];
                    wa[r] = row_a[r] - r_amt[r];
                    wn[r] = row_n[r] + r_amt[r];
                end
                wr_en    = 1'b1;
                wr_alloc = RW'(wa);
                wr_need  = RW'(wn);
                n_status = ST_UNSAFE;
                n_state  = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_avail  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_fin    <= '0;
            r_prog   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_avail  <= n_avail;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            r_fin    <= n_fin;
            r_prog   <= n_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work   <= n_work;
        r_status <= n_status;
        if (r_state == S_IDLE && i_valid && o_ready) begin
            r_op      <= i_operation;
            r_cust    <= CB'(i_customer);
            r_cust_ok <= ({29'd0, i_customer} < CUSTOMERS);
            r_amt     <= amt_in;
        end
    end

endmodule

[hw/rtl/bra_checker.sv]
// ----------------------------------------------------------------------------
// bra_checker
// port-level checks of the allocator handshake and result codes
// ----------------------------------------------------------------------------
module bra_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [bra_pkg::STATUS_BITS-1:0] o_status
);
    import bra_pkg::*;

    // one word in flight: no accept while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input accepted while result pending");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_OVER_REL)) else $error("bad status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped");

    // an accepted word is not followed at once by a valid result
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid) else $error("result too early");

endmodule

bind bankers_resource_allocator bra_checker u_bra_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status)
);

[bench/bankers_resource_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bankers_resource_allocator_tb
// drives request, release and load words through the allocator with random
// idling on both sides and checks every status word against a banker's
// algorithm predictor kept in step with the accepted words
// ----------------------------------------------------------------------------
module bankers_resource_allocator_tb;
    import bra_pkg::*;

    localparam int NC = CUSTOMERS_DEF;
    localparam int NR = RESOURCES_DEF;
    localparam int UMAX = (1 << UNIT_BITS_DEF) - 1;
    localparam int N_RANDOM = 830;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        t_op        op;
        logic [2:0] cust;
        logic [7:0] a0, a1, a2, a3;
        logic       has_exp;
        t_status    exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [1:0] i_operation = '0;
    logic [2:0] i_customer = '0;
    logic [7:0] i_amount_0 = '0, i_amount_1 = '0, i_amount_2 = '0, i_amount_3 = '0;
    logic o_ready, o_valid;
    logic [STATUS_BITS-1:0] o_status;

    int avail_units[NR];
    int alloc_units[NC][NR];
    int need_units[NC][NR];
    t_status status_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet_tail = 0;
    int out_gap = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    bankers_resource_allocator u_dut (.*);

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit system_is_safe();
        int work[NR];
        bit done[NC];
        bit progress, fits;
        work = avail_units;
        foreach (done[c]) done[c] = 0;
        progress = 1;
        while (progress) begin
            progress = 0;
            for (int c = 0; c < NC; c++) begin
                if (!done[c]) begin
                    fits = 1;
                    for (int r = 0; r < NR; r++)
                        if (need_units[c][r] > work[r]) fits = 0;
                    if (fits) begin
                        for (int r = 0; r < NR; r++)
                            work[r] = (work[r] + alloc_units[c][r] > UMAX) ? UMAX
                                      : work[r] + alloc_units[c][r];
                        done[c] = 1;
                        progress = 1;
                    end
                end
            end
        end
        foreach (done[c]) if (!done[c]) return 0;
        return 1;
    endfunction

    function automatic t_status allocate(input t_op op, input int c, input int amt[NR]);
        bit over_need, over_avail, over;
        over_need = 0; over_avail = 0; over = 0;
        case (op)
            OP_REQUEST: begin
                for (int r = 0; r < NR; r++) begin
                    if (amt[r] > need_units[c][r]) over_need = 1;
                    if (amt[r] > avail_units[r]) over_avail = 1;
                end
                if (over_need) return ST_OVER_NEED;
                if (over_avail) return ST_OVER_AVAIL;
                for (int r = 0; r < NR; r++) begin
                    avail_units[r] -= amt[r];
                    alloc_units[c][r] = (alloc_units[c][r] + amt[r] > UMAX) ? UMAX
                                        : alloc_units[c][r] + amt[r];
                    need_units[c][r] -= amt[r];
                end
                if (!system_is_safe()) begin
                    for (int r = 0; r < NR; r++) begin
                        avail_units[r] += amt[r];
                        alloc_units[c][r] -= amt[r];
                        need_units[c][r] += amt[r];
                    end
                    return ST_UNSAFE;
                end
            end
            OP_RELEASE: begin
                for (int r = 0; r < NR; r++)
                    if (amt[r] > alloc_units[c][r]) over = 1;
                if (over) return ST_OVER_REL;
                for (int r = 0; r < NR; r++) begin
                    alloc_units[c][r] -= amt[r];
                    avail_units[r] = (avail_units[r] + amt[r] > UMAX) ? UMAX
                                     : avail_units[r] + amt[r];
                    need_units[c][r] = (need_units[c][r] + amt[r] > UMAX) ? UMAX
                                       : need_units[c][r] + amt[r];
                end
            end
            OP_LOAD_MAX: begin
                for (int r = 0; r < NR; r++)
                    need_units[c][r] = (amt[r] > alloc_units[c][r])
                                       ? amt[r] - alloc_units[c][r] : 0;
            end
            default: begin
                for (int r = 0; r < NR; r++) avail_units[r] = amt[r];
            end
        endcase
        return ST_OK;
    endfunction

    // send one word; a directed expectation, if any, is checked against the predictor too
    task automatic send_word(input t_row w);
        int amt[NR];
        t_status st;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= w.op;
        i_customer <= w.cust;
        i_amount_0 <= w.a0; i_amount_1 <= w.a1;
        i_amount_2 <= w.a2; i_amount_3 <= w.a3;
        do @(posedge i_clk); while (!o_ready);
        amt = '{w.a0, w.a1, w.a2, w.a3};
        st = allocate(w.op, w.cust, amt);
        if (w.has_exp && st != w.exp) report("directed table", st, w.exp);
        status_q.push_back(w.has_exp ? w.exp : st);
    endtask

    function automatic t_row mk(input t_op op, input int c, input int a0, input int a1,
                                input int a2, input int a3, input bit he = 0,
                                input t_status e = ST_OK);
        t_row w;
        w.op = op; w.cust = c[2:0];
        w.a0 = a0[7:0]; w.a1 = a1[7:0]; w.a2 = a2[7:0]; w.a3 = a3[7:0];
        w.has_exp = he; w.exp = e;
        return w;
    endfunction

    // result side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (status_q.size() == 0) begin
                    report("unexpected status word", o_status, -1);
                end else begin
                    if (o_status !== status_q[0]) report("status", o_status, status_q[0]);
                    void'(status_q.pop_front());
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                out_gap <= $urandom_range(1, 9) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted word or taken result
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_row table_rows[$];
        t_row w;
        int c, kind;
        foreach (avail_units[r]) avail_units[r] = 0;
        foreach (alloc_units[i, r]) begin
            alloc_units[i][r] = 0;
            need_units[i][r] = 0;
        end
        // after reset: nothing needed, nothing free
        table_rows.push_back(mk(OP_REQUEST, 0, 0, 0, 0, 0, 1, ST_OK));
        table_rows.push_back(mk(OP_REQUEST, 1, 1, 0, 0, 0, 1, ST_OVER_NEED));
        table_rows.push_back(mk(OP_RELEASE, 2, 0, 0, 0, 1, 1, ST_OVER_REL));
        table_rows.push_back(mk(OP_LOAD_AVAIL, 0, 255, 255, 255, 255, 1, ST_OK));
        table_rows.push_back(mk(OP_LOAD_MAX, 7, 255, 255, 255, 255, 1, ST_OK));
        table_rows.push_back(mk(OP_REQUEST, 7, 255, 255, 255, 255, 1, ST_OK));
        table_rows.push_back(mk(OP_RELEASE, 7, 255, 255, 255, 255, 1, ST_OK));
        table_rows.push_back(mk(OP_LOAD_AVAIL, 0, 10, 10, 10, 10, 1, ST_OK));
        table_rows.push_back(mk(OP_LOAD_MAX, 0, 8, 8, 8, 8, 1, ST_OK));
        table_rows.push_back(mk(OP_LOAD_MAX, 1, 8, 8, 8, 8, 1, ST_OK));
        table_rows.push_back(mk(OP_REQUEST, 0, 12, 0, 0, 0, 1, ST_OVER_NEED));
        table_rows.push_back(mk(OP_REQUEST, 0, 5, 5, 5, 5));
        table_rows.push_back(mk(OP_REQUEST, 1, 5, 5, 5, 5));
        table_rows.push_back(mk(OP_REQUEST, 1, 3, 3, 3, 3));
        table_rows.push_back(mk(OP_LOAD_MAX, 0, 2, 0, 9, 255));
        table_rows.push_back(mk(OP_RELEASE, 0, 6, 0, 0, 0));
        table_rows.push_back(mk(OP_RELEASE, 0, 5, 5, 5, 5));
        table_rows.push_back(mk(OP_LOAD_AVAIL, 0, 250, 250, 250, 250));
        table_rows.push_back(mk(OP_RELEASE, 1, 3, 3, 3, 3));
        table_rows.push_back(mk(OP_REQUEST, 3, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_LOAD_AVAIL, 0, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_rows[i]) send_word(table_rows[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 80) quiet_tail = 1;
            c = $urandom_range(0, NC - 1);
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // request within the current need most of the time
                w = mk(OP_REQUEST, c,
                       $urandom_range(0, need_units[c][0]), $urandom_range(0, need_units[c][1]),
                       $urandom_range(0, need_units[c][2]), $urandom_range(0, need_units[c][3]));
                if ($urandom_range(0, 7) == 0) w.a1 = 8'($urandom);
            end else if (kind < 70) begin
                w = mk(OP_RELEASE, c,
                       $urandom_range(0, alloc_units[c][0]), $urandom_range(0, alloc_units[c][1]),
                       $urandom_range(0, alloc_units[c][2]), $urandom_range(0, alloc_units[c][3]));
                if ($urandom_range(0, 7) == 0) w.a2 = 8'($urandom);
            end else if (kind < 85) begin
                w = mk(OP_LOAD_MAX, c, $urandom_range(0, 60), $urandom_range(0, 60),
                       $urandom_range(0, 60), $urandom_range(0, 60));
                if ($urandom_range(0, 9) == 0) w.a3 = 8'($urandom);
            end else if (kind < 95) begin
                w = mk(OP_LOAD_AVAIL, c, $urandom_range(0, 120), $urandom_range(0, 120),
                       $urandom_range(0, 120), $urandom_range(0, 120));
            end else begin
                w = mk(t_op'($urandom_range(0, 3)), c, $urandom, $urandom, $urandom, $urandom);
            end
            send_word(w);
        end
        i_valid <= 1'b0;

        while (status_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[bankers_resource_allocator.f]
hw/rtl/bra_pkg.sv
hw/rtl/bankers_resource_allocator.sv
hw/rtl/bra_checker.sv
bench/bankers_resource_allocator_tb.sv
